// ===== rtl/core/mrfc_pkg.sv =====
`default_nettype none
package mrfc_pkg;

    localparam int MAX_FRAME = 256;
    localparam int POS_W     = $clog2(MAX_FRAME + 2);

    localparam logic [15:0] CRC_POLY = 16'hA001;
    localparam logic [15:0] CRC_INIT = 16'hFFFF;

    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_EXPECTED_FUNCTION = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PAYLOAD_CAPACITY  = 2'd1;

    localparam logic [7:0] RESET_EXPECTED_FUNCTION = 8'd3;
    localparam logic [7:0] RESET_PAYLOAD_CAPACITY  = 8'd252;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_TOO_SHORT = 3'd1;
    localparam logic [2:0] ST_CRC       = 3'd2;
    localparam logic [2:0] ST_EXCEPTION = 3'd3;
    localparam logic [2:0] ST_FUNCTION  = 3'd4;
    localparam logic [2:0] ST_BUFFER    = 3'd5;

    typedef struct packed {
        logic       pay_valid;
        logic [7:0] pay_byte;
        logic       stat_valid;
        logic [2:0] status;
        logic [7:0] exception_code;
        logic [7:0] payload_length;
    } t_frame_result;

    // One byte through the reflected CRC-16, bit by bit.
    function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/core/modbus_response_frame_checker_top.sv =====
`default_nettype none
// Modbus RTU response checker. Takes one frame byte per cycle, flagged on the last
// byte; the CRC-16 step over a byte is unrolled, so a byte can be accepted in every
// cycle while the output register has room. A byte is registered on acceptance, and
// its results when it steps the frame logic. Payload bytes leave two bytes late with
// kind 0; the final byte gives one status result with kind 1, preceded by the last
// payload byte if any, so that byte gives two results at the single output port.
// Configuration writes take effect at once and belong between frames.
module modbus_response_frame_checker_top (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_wr_en,
    input  wire logic [mrfc_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [7:0]                     i_cfg_data,
    input  wire logic                           i_in_valid,
    output      logic                           o_in_ready,
    input  wire logic [7:0]                     i_rx_byte,
    input  wire logic                           i_last_byte,
    output      logic                           o_out_valid,
    input  wire logic                           i_out_ready,
    output      logic                           o_kind,
    output      logic [7:0]                     o_payload_byte,
    output      logic [2:0]                     o_status,
    output      logic [7:0]                     o_exception_code,
    output      logic [7:0]                     o_payload_length
);

    logic [7:0] r_expected_function;
    logic [7:0] r_payload_capacity;

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_last;

    mrfc_pkg::t_frame_result core_res;
    mrfc_pkg::t_frame_result r_res;

    logic res_take;
    logic res_free;
    logic advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_expected_function <= mrfc_pkg::RESET_EXPECTED_FUNCTION;
            r_payload_capacity  <= mrfc_pkg::RESET_PAYLOAD_CAPACITY;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                mrfc_pkg::CFG_EXPECTED_FUNCTION: r_expected_function <= i_cfg_data;
                mrfc_pkg::CFG_PAYLOAD_CAPACITY:  r_payload_capacity  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign res_take = o_out_valid && i_out_ready;
    // room when empty, or when the last pending result leaves this cycle
    assign res_free = !(r_res.pay_valid || r_res.stat_valid) ||
                      (res_take && (r_res.pay_valid ^ r_res.stat_valid));
    assign advance    = r_in_valid && res_free;
    assign o_in_ready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in_valid && o_in_ready) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in_byte <= i_rx_byte;
            r_in_last <= i_last_byte;
        end
    end

    mrfc_frame_core u_core (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_step              (advance),
        .i_rx_byte           (r_in_byte),
        .i_last_byte         (r_in_last),
        .i_expected_function (r_expected_function),
        .i_payload_capacity  (r_payload_capacity),
        .o_result            (core_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res <= '0;
        end else if (advance) begin
            r_res <= core_res;
        end else if (res_take) begin
            // payload goes first, then the status
            if (r_res.pay_valid) begin
                r_res.pay_valid <= 1'b0;
            end else begin
                r_res.stat_valid <= 1'b0;
            end
        end
    end

    always_comb begin
        o_out_valid      = r_res.pay_valid || r_res.stat_valid;
        o_kind           = !r_res.pay_valid;
        o_payload_byte   = r_res.pay_valid ? r_res.pay_byte : 8'd0;
        o_status         = r_res.pay_valid ? mrfc_pkg::ST_OK : r_res.status;
        o_exception_code = r_res.pay_valid ? 8'd0 : r_res.exception_code;
        o_payload_length = r_res.pay_valid ? 8'd0 : r_res.payload_length;
    end

`ifndef SYNTHESIS
    a_len_only_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_kind && o_status != mrfc_pkg::ST_OK |-> o_payload_length == 8'd0)
        else $error("payload length on a failed frame");
    a_exc_only_exc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_kind && o_status != mrfc_pkg::ST_EXCEPTION
        |-> o_exception_code == 8'd0)
        else $error("exception code without exception status");
    a_in_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !advance |=> r_in_valid && $stable(r_in_byte) && $stable(r_in_last))
        else $error("held request lost");
    a_status_after_pay: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_take && r_res.pay_valid && r_res.stat_valid && !advance
        |=> o_out_valid && o_kind)
        else $error("status lost behind final payload byte");
`endif

endmodule
`default_nettype wire

// ===== rtl/core/mrfc_frame_core.sv =====
`default_nettype none
module mrfc_frame_core (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_step,
    input  wire logic [7:0]            i_rx_byte,
    input  wire logic                  i_last_byte,
    input  wire logic [7:0]            i_expected_function,
    input  wire logic [7:0]            i_payload_capacity,
    output mrfc_pkg::t_frame_result    o_result
);

    localparam int POS_W = mrfc_pkg::POS_W;

    logic [POS_W-1:0] r_pos, n_pos;
    logic [15:0]      r_crc, n_crc;
    logic [7:0]       r_d1, n_d1;
    logic [7:0]       r_d2, n_d2;
    logic [7:0]       r_fn, n_fn;
    logic [7:0]       r_third, n_third;

    logic [15:0]      crc_fed;
    logic             overflow;
    logic             crc_bad;
    logic [POS_W-1:0] plen_full;

    always_comb begin
        overflow  = r_pos >= POS_W'(mrfc_pkg::MAX_FRAME);
        crc_fed   = (r_pos >= POS_W'(2)) ? mrfc_pkg::crc_feed(r_crc, r_d2) : r_crc;
        crc_bad   = (r_d1 != crc_fed[15:8]) || (i_rx_byte != crc_fed[7:0]);
        plen_full = r_pos - POS_W'(3);

        o_result                = '0;
        o_result.pay_valid      = r_pos >= POS_W'(4);
        o_result.pay_byte       = r_d2;
        o_result.stat_valid     = i_last_byte;
        priority if (r_pos < POS_W'(4)) begin
            o_result.status = mrfc_pkg::ST_TOO_SHORT;
        end else if (overflow) begin
            o_result.status = mrfc_pkg::ST_BUFFER;
        end else if (crc_bad) begin
            o_result.status = mrfc_pkg::ST_CRC;
        end else if (r_fn[7]) begin
            o_result.status         = mrfc_pkg::ST_EXCEPTION;
            o_result.exception_code = r_third;
        end else if (r_fn != i_expected_function) begin
            o_result.status = mrfc_pkg::ST_FUNCTION;
        end else if (plen_full > {1'b0, i_payload_capacity}) begin
            o_result.status = mrfc_pkg::ST_BUFFER;
        end else begin
            o_result.status         = mrfc_pkg::ST_OK;
            o_result.payload_length = plen_full[7:0];
        end
    end

    always_comb begin
        n_pos   = r_pos;
        n_crc   = r_crc;
        n_d1    = r_d1;
        n_d2    = r_d2;
        n_fn    = r_fn;
        n_third = r_third;
        if (i_step) begin
            if (i_last_byte) begin
                // frame ends: back to the idle frame state
                n_pos   = '0;
                n_crc   = mrfc_pkg::CRC_INIT;
                n_d1    = '0;
                n_d2    = '0;
                n_fn    = '0;
                n_third = '0;
            end else begin
                n_crc = crc_fed;
                n_d2  = r_d1;
                n_d1  = i_rx_byte;
                if (r_pos == POS_W'(1)) begin
                    n_fn = i_rx_byte;
                end
                if (r_pos == POS_W'(2)) begin
                    n_third = i_rx_byte;
                end
                // saturate one past the maximum frame length
                n_pos = overflow ? POS_W'(mrfc_pkg::MAX_FRAME + 1) : r_pos + POS_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_crc   <= mrfc_pkg::CRC_INIT;
            r_d1    <= '0;
            r_d2    <= '0;
            r_fn    <= '0;
            r_third <= '0;
        end else begin
            r_pos   <= n_pos;
            r_crc   <= n_crc;
            r_d1    <= n_d1;
            r_d2    <= n_d2;
            r_fn    <= n_fn;
            r_third <= n_third;
        end
    end

`ifndef SYNTHESIS
    a_pos_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= POS_W'(mrfc_pkg::MAX_FRAME + 1))
        else $error("byte position beyond saturation");
    a_clear_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && i_last_byte |=> r_pos == '0 && r_crc == mrfc_pkg::CRC_INIT)
        else $error("frame state not cleared after final byte");
    a_pos_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && !i_last_byte && r_pos < POS_W'(mrfc_pkg::MAX_FRAME)
        |=> r_pos == $past(r_pos) + POS_W'(1))
        else $error("byte position did not advance");
`endif

endmodule
`default_nettype wire
